>>> rtl/text_mode_console_writer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the console writer
// Implication checks on the block clock with reset masked.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_MODE_CONSOLE_WRITER_TOP_ASSERT_SVH

// same-cycle implication
`define TCW_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcw check failed");

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcw check failed");

`endif

>>> rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Geometry, character codes, payload words and control types of the console
// writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;
    localparam int CELLS     = COLUMNS * ROWS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int TM_W   = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
    localparam int REM_W  = $clog2(TAB_WIDTH + 1);

    localparam int CELL_W  = 16;
    localparam int ATTR_W  = 8;
    localparam int CODE_W  = 8;
    localparam int FIELD_W = 11;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    localparam logic [CODE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
    localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_TEXT_ATTR = 1'b0;

    typedef struct packed {
        logic               func;
        logic [CODE_W-1:0]  char_code;
        logic [FIELD_W-1:0] cell_addr;
    } cmd_t;

    typedef struct packed {
        logic [FIELD_W-1:0] cursor_pos;
        logic [CELL_W-1:0]  read_data;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_TAB,
        ST_SCROLL
    } state_t;

endpackage

>>> rtl/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic memory, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/tcw_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_regs
// Configuration register file on the APB-style port.
// ----------------------------------------------------------------------------
module tcw_regs
    import tcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [ATTR_W-1:0]  attr
);

    logic [ATTR_W-1:0] attr_reg;
    logic [ATTR_W-1:0] attr_next;

    assign pready = 1'b1;
    assign attr   = attr_reg;

    always_comb
    begin
        attr_next = attr_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_TEXT_ATTR))
        begin
            attr_next = pwdata[ATTR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TEXT_ATTR)
        begin
            prdata = PDATA_W'(attr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

endmodule

>>> rtl/tcw_ctrl.sv
`timescale 1ns / 1ps
`include "text_mode_console_writer_top_assert.svh"
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: decodes a word, edits the screen memory, runs the
// scroll copy and the clearing pass, and drives the result strobe.
// ----------------------------------------------------------------------------
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cmd_t              cmd,
    output logic              busy,
    output logic              done,
    output result_t           result,
    input  logic [ATTR_W-1:0] attr,
    output mem_req_t          mem_req,
    input  logic [CELL_W-1:0] mem_rdata
);

    localparam logic [TM_W-1:0] BS_TMOD = TM_W'((COLUMNS - 1) % TAB_WIDTH);

    state_t            state_reg,  state_next;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg,    col_next;
    logic [TM_W-1:0]   tmod_reg,   tmod_next;
    logic [REM_W-1:0]  rem_reg,    rem_next;
    logic [ADDR_W-1:0] idx_reg,    idx_next;
    logic              done_reg,   done_next;
    cmd_t              cmd_reg,    cmd_next;
    logic              addr_ok_reg, addr_ok_next;
    result_t           result_reg, result_next;

    logic              finish;
    logic [CELL_W-1:0] rd_out;

    logic              at_end;
    logic [ADDR_W-1:0] adv_cursor;
    logic [COL_W-1:0]  adv_col;
    logic [TM_W-1:0]   adv_tmod;
    logic [ADDR_W-1:0] row_start;
    logic              last_row;
    logic [ADDR_W:0]   scr_src;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // cursor step shared by plain characters and tab blanks
    always_comb
    begin
        at_end     = (cursor_reg == ADDR_W'(CELLS - 1));
        adv_cursor = at_end ? ADDR_W'(CELLS - COLUMNS) : cursor_reg + 1'b1;
        adv_col    = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + 1'b1;
        adv_tmod   = ((col_reg == COL_W'(COLUMNS - 1)) || (tmod_reg == TM_W'(TAB_WIDTH - 1)))
                     ? '0 : tmod_reg + 1'b1;
        row_start  = cursor_reg - ADDR_W'(col_reg);
        last_row   = (row_start == ADDR_W'(CELLS - COLUMNS));
        scr_src    = {1'b0, idx_reg} + (ADDR_W + 1)'(COLUMNS + 1);
    end

    always_comb
    begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        col_next     = col_reg;
        tmod_next    = tmod_reg;
        rem_next     = rem_reg;
        idx_next     = idx_reg;
        cmd_next     = cmd_reg;
        addr_ok_next = addr_ok_reg;
        result_next  = result_reg;
        done_next    = 1'b0;
        finish       = 1'b0;
        rd_out       = '0;

        mem_req.we    = 1'b0;
        mem_req.waddr = cursor_reg;
        mem_req.wdata = BLANK_CELL;
        // prime the first scroll source read
        mem_req.raddr = ADDR_W'(COLUMNS);

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg;
                if (idx_reg == ADDR_W'(CELLS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                // read the requested cell right away; data lands in EXEC
                mem_req.raddr = ADDR_W'(cmd.cell_addr);
                if (start)
                begin
                    cmd_next     = cmd;
                    addr_ok_next = (32'(cmd.cell_addr) < CELLS);
                    state_next   = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (cmd_reg.func == FUNC_READ)
                begin
                    rd_out = addr_ok_reg ? mem_rdata : '0;
                    finish = 1'b1;
                end
                else
                begin
                    unique case (cmd_reg.char_code)
                        CH_NUL:
                        begin
                            finish = 1'b1;
                        end
                        CH_BS:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next   = cursor_reg - 1'b1;
                                mem_req.we    = 1'b1;
                                mem_req.waddr = cursor_reg - 1'b1;
                                if (col_reg == '0)
                                begin
                                    col_next  = COL_W'(COLUMNS - 1);
                                    tmod_next = BS_TMOD;
                                end
                                else
                                begin
                                    col_next  = col_reg - 1'b1;
                                    tmod_next = (tmod_reg == '0) ? TM_W'(TAB_WIDTH - 1)
                                                                 : tmod_reg - 1'b1;
                                end
                            end
                            finish = 1'b1;
                        end
                        CH_LF:
                        begin
                            col_next  = '0;
                            tmod_next = '0;
                            if (last_row)
                            begin
                                cursor_next = row_start;
                                idx_next    = '0;
                                state_next  = ST_SCROLL;
                            end
                            else
                            begin
                                cursor_next = row_start + ADDR_W'(COLUMNS);
                                finish      = 1'b1;
                            end
                        end
                        CH_CR:
                        begin
                            cursor_next = row_start;
                            col_next    = '0;
                            tmod_next   = '0;
                            finish      = 1'b1;
                        end
                        CH_TAB:
                        begin
                            rem_next   = REM_W'(TAB_WIDTH) - REM_W'(tmod_reg);
                            state_next = ST_TAB;
                        end
                        default:
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.wdata = {attr, cmd_reg.char_code};
                            cursor_next   = adv_cursor;
                            col_next      = adv_col;
                            tmod_next     = adv_tmod;
                            if (at_end)
                            begin
                                idx_next   = '0;
                                state_next = ST_SCROLL;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                    endcase
                end
            end

            ST_TAB:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = {attr, CH_SPACE};
                cursor_next   = adv_cursor;
                col_next      = adv_col;
                tmod_next     = adv_tmod;
                rem_next      = rem_reg - 1'b1;
                if (at_end)
                begin
                    idx_next   = '0;
                    state_next = ST_SCROLL;
                end
                else if (rem_reg == REM_W'(1))
                begin
                    finish = 1'b1;
                end
            end

            ST_SCROLL:
            begin
                // move row r+1 into row r, blank the last row
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg;
                mem_req.wdata = (idx_reg < ADDR_W'(CELLS - COLUMNS)) ? mem_rdata : BLANK_CELL;
                mem_req.raddr = (scr_src < (ADDR_W + 1)'(CELLS)) ? scr_src[ADDR_W-1:0] : '0;
                if (idx_reg == ADDR_W'(CELLS - 1))
                begin
                    idx_next = '0;
                    if (rem_reg != '0)
                    begin
                        state_next = ST_TAB;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (finish)
        begin
            state_next             = ST_IDLE;
            done_next              = 1'b1;
            result_next.cursor_pos = FIELD_W'(cursor_next);
            result_next.read_data  = rd_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cursor_reg <= '0;
            col_reg    <= '0;
            tmod_reg   <= '0;
            rem_reg    <= '0;
            idx_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            tmod_reg   <= tmod_next;
            rem_reg    <= rem_next;
            idx_reg    <= idx_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        addr_ok_reg <= addr_ok_next;
        result_reg  <= result_next;
    end

    `TCW_ASSERT_SAME(a_cursor_range, 1'b1, 32'(cursor_reg) < CELLS)
    `TCW_ASSERT_SAME(a_col_range, 1'b1, 32'(col_reg) < COLUMNS)
    `TCW_ASSERT_SAME(a_done_idle, done_reg, state_reg == ST_IDLE)
    `TCW_ASSERT_NEXT(a_accept_exec, start && !busy, state_reg == ST_EXEC)
    `TCW_ASSERT_SAME(a_scroll_no_overlap, state_reg == ST_SCROLL,
                     mem_req.waddr != mem_req.raddr)

endmodule

>>> rtl/text_mode_console_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_console_writer_top
// Text console writer: a screen memory of cells and a cursor, edited by put
// words and sampled by read words.
// ----------------------------------------------------------------------------
//   channel   | signals                               | transfer
//   ----------+---------------------------------------+---------------------
//   command   | start, busy, cmd                      | start && !busy
//   result    | done, result                          | done, one cycle
//   config    | psel penable pwrite paddr pwdata ...  | access phase
//
// A read or a plain put is done in EXEC; a tab then writes its blanks in TAB, and
// each scroll moves every screen cell (one memory write port moves one cell).
// After reset a clearing pass blanks every cell, one per cycle, with busy high;
// configuration writes are taken at any time.
// Results are strobed for one cycle and the receiver cannot stall them.
// ----------------------------------------------------------------------------
module text_mode_console_writer_top
    import tcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cmd_t               cmd,
    output logic               busy,
    output logic               done,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [ATTR_W-1:0] attr;
    mem_req_t          mem_req;
    logic [CELL_W-1:0] mem_rdata;

    tcw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .attr    (attr)
    );

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .attr      (attr),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule
